[rtl/nms3d_pkg.sv]
// ----------------------------------------------------------------------------
// nms3d_pkg
// Shared types and constants of the 3D box suppression core.
// ----------------------------------------------------------------------------
`default_nettype none

package nms3d_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int ID_W      = 16;
  localparam int CRD_W     = 16;
  localparam int VOL_W     = 49;
  localparam int THR_W     = 17;
  localparam int TOTAL_W   = 7;
  localparam int FRAC_BITS = 16;

  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

  typedef struct packed {
    logic [ID_W-1:0]  box_id;
    logic [CRD_W-1:0] x_low;
    logic [CRD_W-1:0] y_low;
    logic [CRD_W-1:0] x_high;
    logic [CRD_W-1:0] y_high;
    logic [CRD_W-1:0] z_low;
    logic [CRD_W-1:0] z_high;
    logic [VOL_W-1:0] volume;
    logic             last_box;
  } in_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]    kept_id;
    logic [TOTAL_W-1:0] kept_total;
    logic               final_kept;
    logic               overflow;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/nms_3d_box_suppression_core.sv]
// ----------------------------------------------------------------------------
// nms_3d_box_suppression_core
// Greedy 3D non-maximum suppression over one set of score-ordered boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Boxes enter on in_data, one beat per edge with start high and busy low,
//   in descending score order. busy stays low until the beat with last_box
//   set. That beat starts the sweep.
//   The sweep visits entries in arrival order; each kept box is compared with
//   every later entry, one pair at a time through the overlap pipeline
//   (extents, two products, union, threshold products, compare/write-back).
//   Then the kept ids leave as out_valid strobes from the kept-id memory,
//   never back to back; the receiver cannot stall them. busy falls with the
//   last beat and the next set may start. cfg_we writes the Q1.16
//   threshold; reset sets it to 0.5 and empties the set. Box contents need
//   no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_3d_box_suppression_core
  import nms3d_pkg::*;
#(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_beat_t         in_data,
  output logic                  out_valid,
  output out_beat_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  localparam int SC     = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;
  localparam int EXT_W  = SC + 1;
  localparam int XY_W   = 2 * EXT_W;
  localparam int INT_W  = 3 * EXT_W;
  localparam int SUM_W  = VOL_W + 1;
  localparam int DW     = SUM_W + 2;
  localparam int CMP_W  = SUM_W + THR_W + 1;
  localparam int IDX_W  = $clog2(MAX_BOXES);
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SC-1:0]    xl;
    logic [SC-1:0]    yl;
    logic [SC-1:0]    xh;
    logic [SC-1:0]    yh;
    logic [SC-1:0]    zl;
    logic [SC-1:0]    zh;
    logic [VOL_W-1:0] vol;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_IRD, S_ICHK, S_JRD, S_J0, S_J1, S_J2, S_J3, S_J4, S_J5,
    S_ERD, S_EOUT
  } state_t;

  function automatic logic [EXT_W-1:0] extent(input logic [SC-1:0] alo,
                                              input logic [SC-1:0] ahi,
                                              input logic [SC-1:0] blo,
                                              input logic [SC-1:0] bhi);
    logic [SC-1:0] lo;
    logic [SC-1:0] hi;
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    if (hi < lo) return '0;
    return {1'b0, hi - lo} + EXT_W'(1);
  endfunction

  entry_t          box_mem [MAX_BOXES];
  logic            sup_mem [MAX_BOXES];
  logic [ID_W-1:0] kept_mem [MAX_BOXES];

  state_t           state_r;
  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] count_r, i_r, j_r, k_r, kcnt_r;
  logic             ovf_r;
  entry_t           a_r, rd_box_r;
  logic             rd_sup_r;
  logic [ID_W-1:0]  kept_q_r;
  logic [EXT_W-1:0] ex_r, ey_r, ez_r;
  logic [SUM_W-1:0] sum_r, uni_r;
  logic             sup_j_r, degen_r;
  logic [XY_W-1:0]  xy_r;
  logic [INT_W-1:0] inter_r;
  logic [CMP_W-1:0] p0_r, p1_r;
  logic             out_valid_r;
  out_beat_t        out_data_r;

  logic [IDX_W-1:0] rd_addr;
  logic [DW-1:0]    sum_w, inter_w, diff_w;
  logic [CMP_W-1:0] lhs_w, rhs_w;
  logic             hit_w;
  logic [CNT_W+TOTAL_W-1:0] total_w;
  entry_t           wr_entry;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_addr = (state_r == S_IRD) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign sum_w   = DW'(sum_r);
  assign inter_w = DW'(inter_r);
  assign diff_w  = sum_w - inter_w;
  // inter * 2^16 against threshold * union
  assign lhs_w   = CMP_W'(inter_r) << FRAC_BITS;
  assign rhs_w   = (p1_r << 32) + p0_r;
  assign hit_w   = !sup_j_r && (degen_r || (lhs_w >= rhs_w));
  assign total_w = {{TOTAL_W{1'b0}}, kcnt_r};

  always_comb begin
    wr_entry.id  = in_data.box_id;
    wr_entry.xl  = in_data.x_low[SC-1:0];
    wr_entry.yl  = in_data.y_low[SC-1:0];
    wr_entry.xh  = in_data.x_high[SC-1:0];
    wr_entry.yh  = in_data.y_high[SC-1:0];
    wr_entry.zl  = in_data.z_low[SC-1:0];
    wr_entry.zh  = in_data.z_high[SC-1:0];
    wr_entry.vol = in_data.volume;
  end

  // memories
  always_ff @(posedge clk) begin
    rd_box_r <= box_mem[rd_addr];
    rd_sup_r <= sup_mem[rd_addr];
    kept_q_r <= kept_mem[k_r[IDX_W-1:0]];
    if (state_r == S_IDLE && start && count_r < CNT_W'(MAX_BOXES)) begin
      box_mem[count_r[IDX_W-1:0]] <= wr_entry;
      sup_mem[count_r[IDX_W-1:0]] <= 1'b0;
    end else if (state_r == S_J5 && hit_w) begin
      sup_mem[j_r[IDX_W-1:0]] <= 1'b1;
    end
    if (state_r == S_ICHK && !rd_sup_r) begin
      kept_mem[kcnt_r[IDX_W-1:0]] <= rd_box_r.id;
    end
  end

  // overlap pipeline
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_J0: begin
        ex_r    <= extent(a_r.xl, a_r.xh, rd_box_r.xl, rd_box_r.xh);
        ey_r    <= extent(a_r.yl, a_r.yh, rd_box_r.yl, rd_box_r.yh);
        ez_r    <= extent(a_r.zl, a_r.zh, rd_box_r.zl, rd_box_r.zh);
        sum_r   <= SUM_W'(a_r.vol) + SUM_W'(rd_box_r.vol);
        sup_j_r <= rd_sup_r;
      end
      S_J1: xy_r    <= XY_W'(ex_r) * XY_W'(ey_r);
      S_J2: inter_r <= INT_W'(xy_r) * INT_W'(ez_r);
      S_J3: begin
        degen_r <= (sum_w <= inter_w);
        uni_r   <= diff_w[SUM_W-1:0];
      end
      S_J4: begin
        p0_r <= CMP_W'(uni_r[31:0]) * CMP_W'(thr_r);
        p1_r <= CMP_W'(uni_r[SUM_W-1:32]) * CMP_W'(thr_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) thr_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (count_r < CNT_W'(MAX_BOXES)) count_r <= count_r + 1'b1;
            else                             ovf_r   <= 1'b1;
            if (in_data.last_box) begin
              i_r     <= '0;
              kcnt_r  <= '0;
              state_r <= S_IRD;
            end
          end
        end
        S_IRD: state_r <= S_ICHK;
        S_ICHK: begin
          if (rd_sup_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= (i_r + 1'b1 == count_r) ? S_ERD : S_IRD;
          end else begin
            a_r    <= rd_box_r;
            kcnt_r <= kcnt_r + 1'b1;
            j_r    <= i_r + 1'b1;
            if (i_r + 1'b1 == count_r) begin
              state_r <= S_ERD;
            end else begin
              state_r <= S_JRD;
            end
          end
          k_r <= '0;
        end
        S_JRD: state_r <= S_J0;
        S_J0:  state_r <= S_J1;
        S_J1:  state_r <= S_J2;
        S_J2:  state_r <= S_J3;
        S_J3:  state_r <= S_J4;
        S_J4:  state_r <= S_J5;
        S_J5: begin
          if (j_r + 1'b1 == count_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= (i_r + 1'b1 == count_r) ? S_ERD : S_IRD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_JRD;
          end
        end
        S_ERD: state_r <= S_EOUT;
        S_EOUT: begin
          out_valid_r           <= 1'b1;
          out_data_r.kept_id    <= kept_q_r;
          out_data_r.kept_total <= total_w[TOTAL_W-1:0];
          out_data_r.final_kept <= (k_r + 1'b1 == kcnt_r);
          out_data_r.overflow   <= ovf_r;
          k_r                   <= k_r + 1'b1;
          if (k_r + 1'b1 == kcnt_r) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_ERD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/nms3d_checker.sv]
// ----------------------------------------------------------------------------
// nms3d_checker
// Port-level checks of the 3D box suppression core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module nms3d_checker
  import nms3d_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_beat_t  in_data,
  input wire logic      out_valid,
  input wire out_beat_t out_data
);

  // result beats never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats back to back");

  // the final beat frees the block, earlier ones do not
  a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy != out_data.final_kept))
    else $error("busy does not match final beat");

  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.last_box |=> !busy && !out_valid)
    else $error("block left idle on a plain load beat");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last_box |=> busy)
    else $error("sweep did not start");

endmodule

bind nms_3d_box_suppression_core nms3d_checker u_nms3d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D box suppression core. A short table of
// directed boxes is followed by random box sets under several thresholds;
// every kept-id beat is checked against a behavioral predictor or, for lone boxes, a typed-in beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import nms3d_pkg::*;

  localparam int STORE_DEPTH = MAX_BOXES_DEF;
  localparam int IDLE_LIMIT  = 200000;
  localparam int RAND_ITEMS  = 155;
  localparam int DRAIN_WAIT  = 20;
  localparam int CFG_GUARD   = 8;

  typedef struct {
    in_beat_t  beat;
    bit        has_exp;
    out_beat_t exp;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_beat_t          in_data;
  logic              out_valid;
  out_beat_t         out_data;
  logic              cfg_we;
  logic [THR_W-1:0]  cfg_wdata;

  // predictor state
  in_beat_t          set_store [STORE_DEPTH];
  bit                set_supp  [STORE_DEPTH];
  int                set_count;
  bit                set_ovf;
  logic [THR_W-1:0]  cur_thr;

  out_beat_t         kept_q[$];
  int                errors;
  int                beats_in;
  int                beats_out;
  int                sets_done;
  int                ovf_sets;
  int                idle_cycles;
  row_t              dir_rows[$];

  nms_3d_box_suppression_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] span(logic [15:0] alo, logic [15:0] ahi,
                                       logic [15:0] blo, logic [15:0] bhi);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    return (hi < lo) ? 64'd0 : 64'(hi - lo) + 64'd1;
  endfunction

  function automatic bit hits(in_beat_t a, in_beat_t b, logic [THR_W-1:0] thr);
    logic [63:0]  inter;
    logic [63:0]  vsum;
    logic [127:0] lhs;
    logic [127:0] rhs;
    inter = span(a.x_low, a.x_high, b.x_low, b.x_high)
          * span(a.y_low, a.y_high, b.y_low, b.y_high)
          * span(a.z_low, a.z_high, b.z_low, b.z_high);
    vsum = 64'(a.volume) + 64'(b.volume);
    if (vsum <= inter) return 1'b1;
    lhs = 128'(inter) << FRAC_BITS;
    rhs = 128'(thr) * 128'(vsum - inter);
    return lhs >= rhs;
  endfunction

  // fold one accepted beat into the set; on the closing beat queue the kept ids
  task automatic predict_kept(in_beat_t b, bit has_exp, out_beat_t exp);
    logic [ID_W-1:0] ids[$];
    out_beat_t       r;
    if (set_count < STORE_DEPTH) begin
      set_store[set_count] = b;
      set_supp[set_count]  = 1'b0;
      set_count++;
    end else begin
      set_ovf = 1'b1;
    end
    if (b.last_box) begin
      for (int i = 0; i < set_count; i++) begin
        if (!set_supp[i]) begin
          ids.push_back(set_store[i].box_id);
          for (int j = i + 1; j < set_count; j++)
            if (!set_supp[j] && hits(set_store[i], set_store[j], cur_thr))
              set_supp[j] = 1'b1;
        end
      end
      if (has_exp) begin
        kept_q.push_back(exp);
      end else begin
        foreach (ids[k]) begin
          r.kept_id    = ids[k];
          r.kept_total = TOTAL_W'(ids.size());
          r.final_kept = (k == ids.size() - 1);
          r.overflow   = set_ovf;
          kept_q.push_back(r);
        end
      end
      if (set_ovf) ovf_sets++;
      sets_done++;
      set_count = 0;
      set_ovf   = 1'b0;
    end
  endtask

  task automatic send_box(in_beat_t b, bit has_exp, out_beat_t exp);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    beats_in++;
    predict_kept(b, has_exp, exp);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (CFG_GUARD) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_thr   = v;
  endtask

  function automatic in_beat_t mk_box(logic [15:0] id, logic [15:0] xl, logic [15:0] xh,
                                      logic [15:0] yl, logic [15:0] yh, logic [15:0] zl,
                                      logic [15:0] zh, logic [VOL_W-1:0] vol, bit last);
    in_beat_t b;
    b.box_id = id;
    b.x_low  = xl;
    b.x_high = xh;
    b.y_low  = yl;
    b.y_high = yh;
    b.z_low  = zl;
    b.z_high = zh;
    b.volume = vol;
    b.last_box = last;
    return b;
  endfunction

  function automatic logic [15:0] clip(int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hffff : 16'(v);
  endfunction

  // boxes scattered around one center so that many pairs overlap
  task automatic send_set(int n);
    int        cx, cy, cz, hx, hy, hz, jit, kind;
    in_beat_t  b;
    out_beat_t none;
    none = '0;
    jit  = $urandom_range(0, 3) == 0 ? 2000 : 20;
    cx = $urandom_range(0, 65535);
    cy = $urandom_range(0, 65535);
    cz = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      hx = $urandom_range(0, 30);
      hy = $urandom_range(0, 30);
      hz = $urandom_range(0, 30);
      b.box_id = 16'($urandom());
      b.x_low  = clip(cx - hx + $urandom_range(0, 2 * jit) - jit);
      b.x_high = clip(int'(b.x_low) + 2 * hx);
      b.y_low  = clip(cy - hy + $urandom_range(0, 2 * jit) - jit);
      b.y_high = clip(int'(b.y_low) + 2 * hy);
      b.z_low  = clip(cz - hz + $urandom_range(0, 2 * jit) - jit);
      b.z_high = clip(int'(b.z_low) + 2 * hz);
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        b.x_low  = 16'($urandom());
        b.x_high = 16'($urandom());
        b.y_low  = 16'($urandom());
        b.y_high = 16'($urandom());
        b.z_low  = 16'($urandom());
        b.z_high = 16'($urandom());
      end
      if (kind == 1) b.volume = {17'($urandom()), 32'($urandom())};
      else if (kind == 2) b.volume = VOL_W'($urandom_range(1, 8));
      else b.volume = VOL_W'(span(b.x_low, b.x_high, b.x_low, b.x_high)
                           * span(b.y_low, b.y_high, b.y_low, b.y_high)
                           * span(b.z_low, b.z_high, b.z_low, b.z_high));
      if (b.volume == '0) b.volume = VOL_W'(1);
      b.last_box = (i == n - 1);
      send_box(b, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid) begin
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected beat act=%p", $time, out_data);
          errors++;
        end else begin
          if (out_data.kept_id !== kept_q[0].kept_id)
            $display("%0t: kept_id exp=%h act=%h", $time, kept_q[0].kept_id,
                     out_data.kept_id);
          if (out_data.kept_total !== kept_q[0].kept_total)
            $display("%0t: kept_total exp=%0d act=%0d", $time, kept_q[0].kept_total,
                     out_data.kept_total);
          if (out_data.final_kept !== kept_q[0].final_kept)
            $display("%0t: final_kept exp=%b act=%b", $time, kept_q[0].final_kept,
                     out_data.final_kept);
          if (out_data.overflow !== kept_q[0].overflow)
            $display("%0t: overflow exp=%b act=%b", $time, kept_q[0].overflow,
                     out_data.overflow);
          if (out_data !== kept_q[0]) errors++;
          void'(kept_q.pop_front());
        end
        beats_out++;
      end
      if (out_valid || (start && !busy) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [THR_W-1:0] thr_list[$];
    out_beat_t        e;
    int               rand_items;
    int               phase;
    int               n;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    errors = 0; beats_in = 0; beats_out = 0; sets_done = 0; ovf_sets = 0;
    set_count = 0;
    set_ovf   = 1'b0;
    cur_thr   = THR_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; lone boxes are always kept, so their beat is typed in
    e = '{kept_id: 16'h0000, kept_total: 7'd1, final_kept: 1'b1, overflow: 1'b0};
    dir_rows.push_back('{mk_box(16'h0000, 0, 0, 0, 0, 0, 0, 1, 1), 1'b1, e});
    e = '{kept_id: 16'hffff, kept_total: 7'd1, final_kept: 1'b1, overflow: 1'b0};
    dir_rows.push_back('{mk_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                16'hffff, 16'hffff, '1, 1), 1'b1, e});
    e = '0;
    // identical pair
    dir_rows.push_back('{mk_box(1, 0, 9, 0, 9, 0, 9, 1000, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(2, 0, 9, 0, 9, 0, 9, 1000, 1), 1'b0, e});
    // disjoint pair
    dir_rows.push_back('{mk_box(3, 0, 9, 0, 9, 0, 9, 1000, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(4, 50, 59, 0, 9, 0, 9, 1000, 1), 1'b0, e});
    // inverted second box
    dir_rows.push_back('{mk_box(5, 10, 20, 10, 20, 10, 20, 1331, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(6, 20, 10, 10, 20, 10, 20, 5, 1), 1'b0, e});
    // degenerate union: tiny volumes against a large intersection
    dir_rows.push_back('{mk_box(7, 0, 99, 0, 99, 0, 99, 1, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(8, 0, 99, 0, 99, 0, 99, 1, 1), 1'b0, e});
    // chain of partial overlaps
    dir_rows.push_back('{mk_box(9, 0, 9, 0, 9, 0, 9, 1000, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(10, 2, 11, 0, 9, 0, 9, 1000, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(11, 4, 13, 0, 9, 0, 9, 1000, 1), 1'b0, e});
    // full-range pair, widest products
    dir_rows.push_back('{mk_box(12, 0, 16'hffff, 0, 16'hffff, 0, 16'hffff,
                                49'h1_0000_0000_0000, 0), 1'b0, e});
    dir_rows.push_back('{mk_box(13, 0, 16'hffff, 0, 16'hffff, 0, 16'hffff,
                                49'h1_0000_0000_0000, 1), 1'b0, e});
    foreach (dir_rows[i]) send_box(dir_rows[i].beat, dir_rows[i].has_exp, dir_rows[i].exp);

    thr_list = '{17'd0, 17'd65536, 17'd131071, 17'($urandom_range(1, 65535)),
                 17'd16384, THR_RESET, 17'($urandom_range(20000, 50000))};
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS || phase < thr_list.size()) begin
      if (phase < thr_list.size()) write_threshold(thr_list[phase]);
      for (int s = 0; s < 3; s++) begin
        if (phase == 3 && s == 0) n = STORE_DEPTH;
        else if (phase == 5 && s == 0) n = STORE_DEPTH + 2;
        else n = $urandom_range(1, 3);
        if (s == 2) wait_drained();
        send_set(n);
        rand_items += n;
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d boxes in %0d sets (%0d with overflow), %0d kept beats",
             beats_in, sets_done, ovf_sets, beats_out);
    $display("thresholds from zero to above one, including degenerate unions");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
